// ===== sv/assert_macros.svh =====
// Assertion macros for the checker module of the RGB to HSL block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define RHSL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define RHSL_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/rhsl_pkg.sv =====
// Types, constants and helper functions of the RGB to HSL converter.
package rhsl_pkg;

   // Default number of fraction bits of the hue output.
   localparam int RHSL_HUE_FRAC_BITS = 6;

   // Field widths.
   localparam int CHAN_W    = 8;
   localparam int HUE_W     = 15;
   localparam int SAT_W     = 16;
   localparam int LIGHT_W   = 9;
   localparam int HUE_SUM_W = 20;

   // Divider geometry: both quotients fit in 16 bits, the divisor in 8.
   localparam int QUO_W           = 16;
   localparam int NUM_W           = CHAN_W + QUO_W;
   localparam int STEPS_PER_STAGE = 2;
   localparam int DIV_STAGES      = QUO_W / STEPS_PER_STAGE;

   localparam logic [SAT_W-1:0] SAT_MAX = '1;

   // Input beat.
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rhsl_pixel_type;

   // Result beat.
   typedef struct packed {
      logic [HUE_W-1:0]   hue_fixed;
      logic [SAT_W-1:0]   saturation_fixed;
      logic [LIGHT_W-1:0] lightness_sum;
   } rhsl_result_type;

   // Sixty-degree hue sectors; the code times 60 is the sector start.
   typedef enum logic [2:0] {
      SEC_RED     = 3'd0,
      SEC_YELLOW  = 3'd1,
      SEC_GREEN   = 3'd2,
      SEC_CYAN    = 3'd3,
      SEC_BLUE    = 3'd4,
      SEC_MAGENTA = 3'd5
   } rhsl_sector_type;

   // First stage: sorted channels and the chosen hue terms.
   typedef struct packed {
      logic [CHAN_W-1:0] max_val;
      logic [CHAN_W-1:0] min_val;
      logic [CHAN_W-1:0] pos_val;
      logic [CHAN_W-1:0] neg_val;
      logic              flip;
      rhsl_sector_type   sector;
   } rhsl_sort_type;

   // One restoring divider lane: partial remainder, remaining numerator
   // bits that turn into quotient bits, and the divisor.
   typedef struct packed {
      logic [CHAN_W-1:0] rem;
      logic [QUO_W-1:0]  acc;
      logic [CHAN_W-1:0] divisor;
   } rhsl_lane_type;

   // Divider pipeline word: both lanes plus what the output stage needs.
   typedef struct packed {
      rhsl_lane_type      hue;
      rhsl_lane_type      sat;
      rhsl_sector_type    sector;
      logic               grey;
      logic [LIGHT_W-1:0] sum;
   } rhsl_div_type;

   // One step of restoring division: shift in a numerator bit, subtract
   // the divisor when it fits, shift the quotient bit in at the bottom.
   function automatic rhsl_lane_type div_step(rhsl_lane_type lane);
      logic [CHAN_W:0] trial;
      rhsl_lane_type   nxt;
      trial = {lane.rem, lane.acc[QUO_W-1]};
      nxt   = lane;
      if (trial >= {1'b0, lane.divisor}) begin
         nxt.rem = CHAN_W'(trial - {1'b0, lane.divisor});
         nxt.acc = {lane.acc[QUO_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial[CHAN_W-1:0];
         nxt.acc = {lane.acc[QUO_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   // Start of a sector in whole degrees.
   function automatic logic [8:0] sector_base(rhsl_sector_type sector);
      logic [8:0] deg;
      case (sector)
         SEC_RED:     deg = 9'd0;
         SEC_YELLOW:  deg = 9'd60;
         SEC_GREEN:   deg = 9'd120;
         SEC_CYAN:    deg = 9'd180;
         SEC_BLUE:    deg = 9'd240;
         SEC_MAGENTA: deg = 9'd300;
         default:     deg = 9'd0;
      endcase
      return deg;
   endfunction

endpackage

// ===== sv/rgb_to_hsl.sv =====
// RGB to HSL converter, top level.
//
// Input channel req_: one 8-bit RGB pixel per beat (req_valid, req_stall,
// req_pixel). Result channel rsp_: one beat per pixel carrying hue in
// degrees times 2^HUE_FRAC_BITS, saturation times 65535 and lightness as
// max plus min (rsp_valid, rsp_stall, rsp_result). A beat moves at a clock
// edge with valid high and stall low.
// Throughput is one pixel per clock unless the receiver stalls. From acceptance
// to the result beat a pixel passes two front stages (sort, then operand
// setup), eight divider stages with two restoring steps each for the two
// 16-bit quotients, and the rounding stage that is also the output register.
// Every stage has its own valid bit, so bubbles close up while the
// receiver stalls; req_stall rises only when all eleven stages are full
// and rsp_stall is high. A stalled result beat holds its value.
// Synchronous reset empties the pipeline; results then start from the
// first pixel accepted after reset.
module rgb_to_hsl #(
   parameter int HUE_FRAC_BITS = rhsl_pkg::RHSL_HUE_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  rhsl_pkg::rhsl_pixel_type  req_pixel,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rhsl_pkg::rhsl_result_type rsp_result
);
   import rhsl_pkg::*;

   // Chain signals: entry i feeds divider stage i, the last entry the
   // output stage.
   logic         div_valid [DIV_STAGES+1];
   rhsl_div_type div_data  [DIV_STAGES+1];
   logic         div_load  [DIV_STAGES+1];
   logic         front_load;

   assign req_stall = !front_load;

   rhsl_classify #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) u_classify (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_pixel  (req_pixel),
      .in_load   (front_load),
      .next_load (div_load[0]),
      .out_valid (div_valid[0]),
      .out_data  (div_data[0])
   );

   // Divider stages.
   for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
      rhsl_div_stage u_div_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (div_valid[i]),
         .in_data   (div_data[i]),
         .in_load   (div_load[i]),
         .next_load (div_load[i+1]),
         .out_valid (div_valid[i+1]),
         .out_data  (div_data[i+1])
      );
   end

   rhsl_finish #(
      .HUE_FRAC_BITS (HUE_FRAC_BITS)
   ) u_finish (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid[DIV_STAGES]),
      .in_data    (div_data[DIV_STAGES]),
      .in_load    (div_load[DIV_STAGES]),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

endmodule

// ===== sv/rhsl_classify.sv =====
// Front stages: channel sort, sector choice and divider operand setup.
module rhsl_classify #(
   parameter int HUE_FRAC_BITS = rhsl_pkg::RHSL_HUE_FRAC_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  rhsl_pkg::rhsl_pixel_type in_pixel,
   output logic                   in_load,
   input  logic                   next_load,
   output logic                   out_valid,
   output rhsl_pkg::rhsl_div_type out_data
);
   import rhsl_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   rhsl_sort_type     s1_data_ff, s1_data_in;
   logic              s2_valid_ff, s2_valid_in;
   rhsl_div_type      s2_data_ff, s2_data_in;
   logic              load1, load2;

   logic [CHAN_W-1:0] r, g, b;
   logic              red_top, green_top;

   logic [CHAN_W-1:0] delta, m_val;
   logic [LIGHT_W-1:0] sum;
   logic [CHAN_W-1:0] den;
   logic [13:0]       m60;
   logic [NUM_W-1:0]  hue_num, sat_num;

   // A stage takes a new beat when it is empty or its content moves on.
   assign load2   = !s2_valid_ff || next_load;
   assign load1   = !s1_valid_ff || load2;
   assign in_load = load1;

   // Stage one: find maximum and minimum, pick the sector and hue terms.
   always_comb begin
      r         = in_pixel.red;
      g         = in_pixel.green;
      b         = in_pixel.blue;
      red_top   = (r >= g) && (r >= b);
      green_top = !red_top && (g >= b);

      s1_data_in.max_val = red_top ? r : (green_top ? g : b);
      s1_data_in.min_val = ((r <= g) && (r <= b)) ? r : ((g <= b) ? g : b);

      if (red_top) begin
         s1_data_in.pos_val = g;
         s1_data_in.neg_val = b;
         s1_data_in.flip    = (g < b);
         s1_data_in.sector  = (g < b) ? SEC_MAGENTA : SEC_RED;
      end else if (green_top) begin
         s1_data_in.pos_val = b;
         s1_data_in.neg_val = r;
         s1_data_in.flip    = (b < r);
         s1_data_in.sector  = (b < r) ? SEC_YELLOW : SEC_GREEN;
      end else begin
         s1_data_in.pos_val = r;
         s1_data_in.neg_val = g;
         s1_data_in.flip    = (r < g);
         s1_data_in.sector  = (r < g) ? SEC_CYAN : SEC_BLUE;
      end
      s1_valid_in = load1 ? in_valid : s1_valid_ff;
   end

   // Stage two: delta, sum, saturation denominator and both numerators.
   // A sector entered from its far end measures from the sector start,
   // which leaves the hue offset as max minus the falling channel.
   always_comb begin
      delta   = s1_data_ff.max_val - s1_data_ff.min_val;
      sum     = {1'b0, s1_data_ff.max_val} + {1'b0, s1_data_ff.min_val};
      den     = (sum <= LIGHT_W'(255)) ? sum[CHAN_W-1:0]
                                       : CHAN_W'(LIGHT_W'(510) - sum);
      m_val   = s1_data_ff.flip ? (s1_data_ff.max_val - s1_data_ff.neg_val)
                                : (s1_data_ff.pos_val - s1_data_ff.neg_val);
      m60     = {m_val, 6'b0} - {4'b0, m_val, 2'b0};
      hue_num = NUM_W'(m60) << HUE_FRAC_BITS;
      sat_num = {delta, {QUO_W{1'b0}}} - {{QUO_W{1'b0}}, delta};

      s2_data_in.hue.rem     = hue_num[NUM_W-1:QUO_W];
      s2_data_in.hue.acc     = hue_num[QUO_W-1:0];
      s2_data_in.hue.divisor = delta;
      s2_data_in.sat.rem     = sat_num[NUM_W-1:QUO_W];
      s2_data_in.sat.acc     = sat_num[QUO_W-1:0];
      s2_data_in.sat.divisor = den;
      s2_data_in.sector      = s1_data_ff.sector;
      s2_data_in.grey        = (delta == '0);
      s2_data_in.sum         = sum;
      s2_valid_in            = load2 ? s1_valid_ff : s2_valid_ff;
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load1) begin
         s1_data_ff <= s1_data_in;
      end
      if (load2) begin
         s2_data_ff <= s2_data_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_data  = s2_data_ff;

endmodule

// ===== sv/rhsl_div_stage.sv =====
// One divider pipeline stage: STEPS_PER_STAGE restoring steps on both lanes.
module rhsl_div_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  rhsl_pkg::rhsl_div_type in_data,
   output logic                   in_load,
   input  logic                   next_load,
   output logic                   out_valid,
   output rhsl_pkg::rhsl_div_type out_data
);
   import rhsl_pkg::*;

   logic         valid_ff, valid_in;
   rhsl_div_type data_ff, data_in;

   assign in_load = !valid_ff || next_load;

   // Hue and saturation quotients advance side by side.
   always_comb begin
      data_in = in_data;
      for (int s = 0; s < STEPS_PER_STAGE; s++) begin
         data_in.hue = div_step(data_in.hue);
         data_in.sat = div_step(data_in.sat);
      end
      valid_in = in_load ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== sv/rhsl_finish.sv =====
// Output stage: rounding, sector offset, saturation clamp and result register.
module rhsl_finish #(
   parameter int HUE_FRAC_BITS = rhsl_pkg::RHSL_HUE_FRAC_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  rhsl_pkg::rhsl_div_type    in_data,
   output logic                      in_load,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rhsl_pkg::rhsl_result_type rsp_result
);
   import rhsl_pkg::*;

   logic                 valid_ff, valid_in;
   rhsl_result_type      result_ff, result_in;

   logic                 hue_up, sat_up;
   logic [QUO_W:0]       hue_q, sat_q;
   logic [HUE_SUM_W-1:0] hue_full;
   logic [SAT_W-1:0]     sat_val;

   // The output register takes a beat when empty or when its beat leaves.
   assign in_load = !valid_ff || !rsp_stall;

   // Round to nearest, ties up: add one when twice the remainder
   // reaches the divisor.
   always_comb begin
      hue_up   = {in_data.hue.rem, 1'b0} >= {1'b0, in_data.hue.divisor};
      sat_up   = {in_data.sat.rem, 1'b0} >= {1'b0, in_data.sat.divisor};
      hue_q    = {1'b0, in_data.hue.acc} + (QUO_W+1)'(hue_up);
      sat_q    = {1'b0, in_data.sat.acc} + (QUO_W+1)'(sat_up);
      hue_full = (HUE_SUM_W'(sector_base(in_data.sector)) << HUE_FRAC_BITS)
                 + HUE_SUM_W'(hue_q);
      sat_val  = sat_q[QUO_W] ? SAT_MAX : sat_q[SAT_W-1:0];

      // A grey pixel has neither hue nor saturation.
      result_in.hue_fixed        = in_data.grey ? '0 : hue_full[HUE_W-1:0];
      result_in.saturation_fixed = in_data.grey ? '0 : sat_val;
      result_in.lightness_sum    = in_data.sum;
      valid_in                   = in_load ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

endmodule

// ===== sv/rhsl_checker.sv =====
// Port-level checker for the RGB to HSL converter and its bind statement.
`include "assert_macros.svh"

module rhsl_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input rhsl_pkg::rhsl_result_type rsp_result
);

   // A result beat held by the receiver keeps its value.
   `RHSL_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result), "stalled result beat changed")

   // The input only backs up when the output is full and stalled.
   `RHSL_ASSERT(a_req_backpressure, req_valid && req_stall |-> rsp_valid && rsp_stall, "input stalled while the output could move")

   // Zero saturation means a grey pixel, which has zero hue.
   `RHSL_ASSERT(a_grey_hue, rsp_valid && (rsp_result.saturation_fixed == 16'd0) |-> rsp_result.hue_fixed == 15'd0, "zero saturation with nonzero hue")

   // Black and white carry no saturation.
   `RHSL_ASSERT(a_extreme_light, rsp_valid && (rsp_result.lightness_sum == 9'd0 || rsp_result.lightness_sum == 9'd510) |-> rsp_result.saturation_fixed == 16'd0, "black or white with saturation")

   // Reset empties the pipeline.
   `RHSL_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result beat right after reset")

endmodule

bind rgb_to_hsl rhsl_checker u_rhsl_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for the rgb_to_hsl pixel converter.
`timescale 1ns / 100ps

module testbench;
   import rhsl_pkg::*;

   // Hue sector starts in whole degrees.
   localparam int RED_BASE_DEG   = 0;
   localparam int GREEN_BASE_DEG = 120;
   localparam int BLUE_BASE_DEG  = 240;
   localparam int WRAP_DEG       = 360;

   localparam int RANDOM_PIXELS = 1430;
   localparam int DRAIN_CYCLES  = 24;

   // Hand-picked pixels: black, white and greys, the primaries, ties for the
   // maximum, red hues that wrap below zero, tiny and near-full denominators,
   // and the sum boundary around 255.
   localparam int DIRECTED_COUNT = 24;
   localparam logic [23:0] DIRECTED_PIXELS [DIRECTED_COUNT] = '{
      24'h000000, 24'hFFFFFF, 24'h808080, 24'h7F7F7F,
      24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
      24'hFF00FF, 24'h00FFFF, 24'hFF0001, 24'hFF0080,
      24'h010000, 24'h000100, 24'h000001, 24'hFFFEFE,
      24'hFEFFFE, 24'h817F7F, 24'h7F8080, 24'h800000,
      24'h010203, 24'hFDFEFF, 24'h123456, 24'hABCDEF
   };

   // Scoreboard: turns accepted pixels into expected HSL beats and checks
   // result beats against them in order.
   class hsl_scoreboard;
      rhsl_result_type pending[$];
      int errors = 0;

      // Exact fixed-point conversion of one pixel.
      function rhsl_result_type hsl_of(rhsl_pixel_type px);
         int unsigned top, bot, delta, sum, den, pos, neg, base;
         longint t, hue, sat;
         rhsl_result_type res;
         top = px.red;
         bot = px.red;
         if (px.green > top) top = px.green;
         if (px.blue > top) top = px.blue;
         if (px.green < bot) bot = px.green;
         if (px.blue < bot) bot = px.blue;
         delta = top - bot;
         sum   = top + bot;
         hue   = 0;
         sat   = 0;
         if (delta != 0) begin
            // Red wins ties for the maximum, then green.
            if (top == px.red) begin
               pos  = px.green;
               neg  = px.blue;
               base = (px.green >= px.blue) ? RED_BASE_DEG : WRAP_DEG;
            end else if (top == px.green) begin
               pos  = px.blue;
               neg  = px.red;
               base = GREEN_BASE_DEG;
            end else begin
               pos  = px.red;
               neg  = px.green;
               base = BLUE_BASE_DEG;
            end
            t   = longint'(base) * delta + 60 * (longint'(pos) - longint'(neg));
            t   = t <<< RHSL_HUE_FRAC_BITS;
            hue = (2 * t + delta) / (2 * longint'(delta));
            den = (sum <= 255) ? sum : 510 - sum;
            if (den != 0) begin
               sat = (2 * longint'(SAT_MAX) * delta + den) / (2 * longint'(den));
               if (sat > longint'(SAT_MAX)) sat = longint'(SAT_MAX);
            end
         end
         res.hue_fixed        = hue[HUE_W-1:0];
         res.saturation_fixed = sat[SAT_W-1:0];
         res.lightness_sum    = sum[LIGHT_W-1:0];
         return res;
      endfunction

      function void note_pixel(rhsl_pixel_type px);
         pending.push_back(hsl_of(px));
      endfunction

      function void compare_field(string field, int want, int got);
         if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_result(rhsl_result_type got);
         rhsl_result_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         compare_field("hue_fixed", want.hue_fixed, got.hue_fixed);
         compare_field("saturation_fixed", want.saturation_fixed, got.saturation_fixed);
         compare_field("lightness_sum", want.lightness_sum, got.lightness_sum);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   rhsl_pixel_type req_pixel = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rhsl_result_type rsp_result;

   hsl_scoreboard sb = new();
   bit steady = 1'b0;
   int stall_hold = 0;

   rgb_to_hsl #(.HUE_FRAC_BITS(RHSL_HUE_FRAC_BITS)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_pixel  (req_pixel),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   always #2 clock = ~clock;

   // Hold reset from the start, then release it on a falling edge.
   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
   end

   // Idle lengths: mostly short, now and then long.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 75) return $urandom_range(0, 2);
      if (pick < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 40);
   endfunction

   // Receiver stalls held for random stretches; steady phases start none.
   always @(negedge clock) begin
      if (stall_hold > 0) begin
         stall_hold--;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 2) == 0);
         stall_hold = idle_length();
      end
   end

   // Record accepted pixels and check result beats at each rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_pixel(req_pixel);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_result);
      end
   end

   // Offer one pixel beat and return once it has been accepted.
   task automatic send_pixel(input rhsl_pixel_type px);
      int gap;
      gap = (steady || $urandom_range(0, 1)) ? 0 : idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= px;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [7:0] clamp_channel(int value);
      if (value < 0) return 8'd0;
      if (value > 255) return 8'd255;
      return value[7:0];
   endfunction

   // Random pixel drawn from a mix of shapes that hit the corner cases often.
   function automatic rhsl_pixel_type random_pixel();
      rhsl_pixel_type px;
      int kind, level;
      kind = $urandom_range(0, 9);
      px = {8'($urandom), 8'($urandom), 8'($urandom)};
      case (kind)
         5: begin
            // Almost grey: small delta, hue rounding matters most.
            level = $urandom_range(0, 255);
            px.red   = clamp_channel(level + $urandom_range(0, 6) - 3);
            px.green = clamp_channel(level + $urandom_range(0, 6) - 3);
            px.blue  = clamp_channel(level + $urandom_range(0, 6) - 3);
         end
         6: begin
            // Two channels share the maximum.
            level = $urandom_range(1, 255);
            px.red   = level[7:0];
            px.green = level[7:0];
            px.blue  = 8'($urandom_range(0, level));
            if ($urandom_range(0, 2) == 1) {px.green, px.blue} = {px.blue, px.green};
            if ($urandom_range(0, 2) == 2) {px.red, px.blue} = {px.blue, px.red};
         end
         7: begin
            // Channels pinned to the ends of the range.
            if ($urandom_range(0, 1)) px.red = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if ($urandom_range(0, 1)) px.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            if ($urandom_range(0, 1)) px.blue = $urandom_range(0, 1) ? 8'hFF : 8'h00;
         end
         8: begin
            // Exact grey.
            px.green = px.red;
            px.blue  = px.red;
         end
         9: begin
            // Near black or near white, where the denominator is tiny.
            level = $urandom_range(0, 1) ? 0 : 252;
            px.red   = 8'(level + $urandom_range(0, 3));
            px.green = 8'(level + $urandom_range(0, 3));
            px.blue  = 8'(level + $urandom_range(0, 3));
         end
         default: begin
         end
      endcase
      return px;
   endfunction

   // Stimulus: directed pixels, then random ones in alternating phases.
   initial begin
      wait (!reset);
      @(negedge clock);
      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         send_pixel(DIRECTED_PIXELS[i]);
      end
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         steady = ((i % 300) < 60);
         send_pixel(random_pixel());
      end
      req_valid <= 1'b0;
      steady = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #3ms;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/rhsl_pkg.sv
sv/rhsl_classify.sv
sv/rhsl_div_stage.sv
sv/rhsl_finish.sv
sv/rgb_to_hsl.sv
sv/rhsl_checker.sv
sim/testbench.sv
